FILE: rtl/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the serial port register block.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int FRAME_BITS  = 11;
    localparam int OVERSAMPLE  = 16;
    localparam int FRAME_MULT  = FRAME_BITS * OVERSAMPLE;
    localparam int TICKS_W     = 24;

    // opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_RXCHR = 2'd3;

    // register selects
    localparam logic [1:0] REG_DATA = 2'd0;
    localparam logic [1:0] REG_CTRL = 2'd1;
    localparam logic [1:0] REG_DIV  = 2'd2;
    localparam logic [1:0] REG_NONE = 2'd3;

    localparam logic [15:0] CTRL_STORE_MASK = 16'h403F;
    localparam logic [15:0] CTRL_CLEAR_ERR  = 16'h0040;
    localparam logic [15:0] CTRL_TX_IEN     = 16'h0010;
    localparam logic [15:0] CTRL_RX_IEN     = 16'h0020;
    localparam logic [15:0] CTRL_LOW_MASK   = 16'h003F;
    localparam logic [15:0] CTRL_TXBRK      = 16'h4000;
    localparam logic [15:0] STAT_RBF        = 16'h0080;
    localparam logic [15:0] STAT_TBE        = 16'h0100;
    localparam logic [15:0] STAT_OVERRUN    = 16'h0800;
    localparam logic [15:0] STAT_SERIN      = 16'h2000;
    localparam logic [15:0] STAT_TXBRK      = 16'h4000;
    localparam logic [15:0] STAT_ERROR      = 16'h8000;

    localparam logic [TICKS_W-1:0] FRAME_TICKS_RST = TICKS_W'(FRAME_MULT);

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  reg_select;
        logic [15:0] write_data;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq_pulse;
    } t_result;

endpackage

FILE: rtl/spr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_in_if / spr_out_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface spr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [1:0]  reg_select;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, opcode, reg_select, write_data, rx_byte, input ready);
    modport sink   (input valid, opcode, reg_select, write_data, rx_byte, output ready);
endinterface

interface spr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_pulse;

    modport source (output valid, read_data, tx_valid, tx_byte, irq_pulse, input ready);
    modport sink   (input valid, read_data, tx_valid, tx_byte, irq_pulse, output ready);
endinterface

FILE: rtl/spr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_core
// Register state and per-beat update: bus access, transmit double buffer
// with frame timer, receive holding byte with overrun latch.
// ----------------------------------------------------------------------------
module spr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  spr_pkg::t_item   i_item,
    output spr_pkg::t_result o_result
);

    logic [15:0] r_ctrl, n_ctrl;
    logic [15:0] r_div, n_div;
    logic        r_ovr, n_ovr;
    logic [7:0]  r_rx_hold, n_rx_hold;
    logic        r_rx_full, n_rx_full;
    logic [7:0]  r_tx_hold, n_tx_hold;
    logic        r_tx_hold_full, n_tx_hold_full;
    logic [7:0]  r_tx_shift, n_tx_shift;
    logic        r_tx_busy, n_tx_busy;
    logic [spr_pkg::TICKS_W-1:0] r_ticks, n_ticks;
    // frame length for the current divider, refreshed on divider writes
    logic [spr_pkg::TICKS_W-1:0] r_frame, n_frame;

    logic [spr_pkg::TICKS_W-1:0] ticks_dec;
    logic [15:0]                 status;
    logic [16:0]                 div_p1;

    assign ticks_dec = (r_ticks != '0) ? r_ticks - 1'b1 : r_ticks;
    assign div_p1    = {1'b0, i_item.write_data} + 17'd1;

    always_comb begin
        status = r_ctrl & spr_pkg::CTRL_LOW_MASK;
        if (r_rx_full)      status = status | spr_pkg::STAT_RBF;
        if (!r_tx_hold_full) status = status | spr_pkg::STAT_TBE;
        if (r_ovr)          status = status | spr_pkg::STAT_OVERRUN | spr_pkg::STAT_ERROR;
        status = status | spr_pkg::STAT_SERIN;
        if ((r_ctrl & spr_pkg::CTRL_TXBRK) != '0) status = status | spr_pkg::STAT_TXBRK;
    end

    always_comb begin
        n_ctrl         = r_ctrl;
        n_div          = r_div;
        n_ovr          = r_ovr;
        n_rx_hold      = r_rx_hold;
        n_rx_full      = r_rx_full;
        n_tx_hold      = r_tx_hold;
        n_tx_hold_full = r_tx_hold_full;
        n_tx_shift     = r_tx_shift;
        n_tx_busy      = r_tx_busy;
        n_ticks        = r_ticks;
        n_frame        = r_frame;
        o_result       = '0;

        case (i_item.opcode)
            spr_pkg::OP_READ: begin
                case (i_item.reg_select)
                    spr_pkg::REG_DATA: begin
                        o_result.read_data = {8'd0, r_rx_hold};
                        n_rx_full          = 1'b0;
                    end
                    spr_pkg::REG_CTRL: o_result.read_data = status;
                    spr_pkg::REG_DIV:  o_result.read_data = r_div;
                    default:           o_result.read_data = '0;
                endcase
            end
            spr_pkg::OP_WRITE: begin
                case (i_item.reg_select)
                    spr_pkg::REG_DATA: begin
                        if (!r_tx_busy) begin
                            n_tx_shift = i_item.write_data[7:0];
                            n_tx_busy  = 1'b1;
                            n_ticks    = r_frame;
                        end else begin
                            n_tx_hold      = i_item.write_data[7:0];
                            n_tx_hold_full = 1'b1;
                        end
                    end
                    spr_pkg::REG_CTRL: begin
                        n_ctrl = i_item.write_data & spr_pkg::CTRL_STORE_MASK;
                        if ((i_item.write_data & spr_pkg::CTRL_CLEAR_ERR) != '0) begin
                            n_ovr = 1'b0;
                        end
                    end
                    spr_pkg::REG_DIV: begin
                        n_div   = i_item.write_data;
                        n_frame = spr_pkg::TICKS_W'(div_p1 * spr_pkg::TICKS_W'(
                                  spr_pkg::FRAME_MULT));
                    end
                    default: ;
                endcase
            end
            spr_pkg::OP_TICK: begin
                if (r_tx_busy) begin
                    n_ticks = ticks_dec;
                    if (ticks_dec == '0) begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_byte  = r_tx_shift;
                        n_tx_busy         = 1'b0;
                        if (r_tx_hold_full) begin
                            n_tx_shift     = r_tx_hold;
                            n_tx_hold_full = 1'b0;
                            n_tx_busy      = 1'b1;
                            n_ticks        = r_frame;
                            if ((r_ctrl & spr_pkg::CTRL_TX_IEN) != '0) begin
                                o_result.irq_pulse = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                if (r_rx_full) begin
                    n_ovr = 1'b1;
                end else begin
                    n_rx_hold = i_item.rx_byte;
                    n_rx_full = 1'b1;
                end
                if ((r_ctrl & spr_pkg::CTRL_RX_IEN) != '0) o_result.irq_pulse = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl         <= '0;
            r_div          <= '0;
            r_ovr          <= 1'b0;
            r_rx_hold      <= '0;
            r_rx_full      <= 1'b0;
            r_tx_hold      <= '0;
            r_tx_hold_full <= 1'b0;
            r_tx_shift     <= '0;
            r_tx_busy      <= 1'b0;
            r_ticks        <= '0;
            r_frame        <= spr_pkg::FRAME_TICKS_RST;
        end else if (i_fire) begin
            r_ctrl         <= n_ctrl;
            r_div          <= n_div;
            r_ovr          <= n_ovr;
            r_rx_hold      <= n_rx_hold;
            r_rx_full      <= n_rx_full;
            r_tx_hold      <= n_tx_hold;
            r_tx_hold_full <= n_tx_hold_full;
            r_tx_shift     <= n_tx_shift;
            r_tx_busy      <= n_tx_busy;
            r_ticks        <= n_ticks;
            r_frame        <= n_frame;
        end
    end

endmodule

FILE: rtl/serial_port_register_block_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_port_register_block_top
// Beats pass the input register, then the result register; throughput one
// beat per cycle when the output does not stall, set by the state update in
// spr_core; stalls back up through the input register. Reset (synchronous,
// active low) clears valid flags and core state only; no clearing pass.
// ----------------------------------------------------------------------------
module serial_port_register_block_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spr_in_if.sink    i_in,
    spr_out_if.source o_out
);

    logic             r_in_valid;
    spr_pkg::t_item   r_in_item;
    logic             r_out_valid;
    spr_pkg::t_result r_out_res;
    spr_pkg::t_result core_res;
    logic             advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    spr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item.opcode     <= i_in.opcode;
            r_in_item.reg_select <= i_in.reg_select;
            r_in_item.write_data <= i_in.write_data;
            r_in_item.rx_byte    <= i_in.rx_byte;
        end
        if (advance) r_out_res <= core_res;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_res.read_data;
    assign o_out.tx_valid  = r_out_res.tx_valid;
    assign o_out.tx_byte   = r_out_res.tx_byte;
    assign o_out.irq_pulse = r_out_res.irq_pulse;

endmodule
